[design/otalog_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otalog_pkg
// Types, codes and the control program of the over-temperature alarm block.
// ----------------------------------------------------------------------------
package otalog_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned PC_W   = 4;
  localparam int unsigned SLOT_W = 6;

  localparam logic [CFG_AW-1:0] REG_INTERVAL  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ALARM_THR = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RED_THR   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_YEL_THR   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GRN_THR   = 3'd4;

  localparam logic [DATA_W-1:0] RST_INTERVAL  = 16'd1000;
  localparam logic [DATA_W-1:0] RST_ALARM_THR = 16'd3000;
  localparam logic [DATA_W-1:0] RST_RED_THR   = 16'd2500;
  localparam logic [DATA_W-1:0] RST_YEL_THR   = 16'd1800;
  localparam logic [DATA_W-1:0] RST_GRN_THR   = 16'd1000;

  localparam logic [DATA_W-1:0] COUNT_MAX    = 16'hffff;
  localparam logic [DATA_W:0]   CLEAR_MARGIN = 17'd50;

  localparam logic [2:0] COLOR_BLUE   = 3'd0;
  localparam logic [2:0] COLOR_GREEN  = 3'd1;
  localparam logic [2:0] COLOR_YELLOW = 3'd2;
  localparam logic [2:0] COLOR_RED    = 3'd3;
  localparam logic [2:0] COLOR_NONE   = 3'd4;

  localparam logic [1:0] BUZZ_NONE  = 2'd0;
  localparam logic [1:0] BUZZ_START = 2'd1;
  localparam logic [1:0] BUZZ_STOP  = 2'd2;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    U_FETCH,
    U_NOP,
    U_SAMPLE,
    U_RAISE,
    U_APPEND,
    U_RD_ADDR,
    U_RESTORE,
    U_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_RESTORE,
    C_NOT_DUE,
    C_NO_RAISE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_FETCH   = 4'd0;
  localparam pc_t PC_RESTORE = 4'd6;
  localparam pc_t PC_WAIT    = 4'd8;

  // control program: jump to target when cond holds, else step on
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{uop: U_FETCH,   cond: C_NO_REQ,   target: PC_FETCH};
      4'd1:    w = '{uop: U_NOP,     cond: C_RESTORE,  target: PC_RESTORE};
      4'd2:    w = '{uop: U_NOP,     cond: C_NOT_DUE,  target: PC_WAIT};
      4'd3:    w = '{uop: U_SAMPLE,  cond: C_NO_RAISE, target: PC_WAIT};
      4'd4:    w = '{uop: U_RAISE,   cond: C_NEVER,    target: PC_FETCH};
      4'd5:    w = '{uop: U_APPEND,  cond: C_ALWAYS,   target: PC_WAIT};
      4'd6:    w = '{uop: U_RD_ADDR, cond: C_NEVER,    target: PC_FETCH};
      4'd7:    w = '{uop: U_RESTORE, cond: C_NEVER,    target: PC_FETCH};
      4'd8:    w = '{uop: U_NOP,     cond: C_OUT_BUSY, target: PC_WAIT};
      4'd9:    w = '{uop: U_EMIT,    cond: C_ALWAYS,   target: PC_FETCH};
      default: w = '{uop: U_NOP,     cond: C_ALWAYS,   target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

[design/overtemp_alarm_with_wear_levelled_log_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overtemp_alarm_with_wear_levelled_log_top
// A request runs through the control program: fetch, the restore and due
//   checks, then when due the sample, on a raise also the alarm raise and
//   log append, or for a restore the registered log memory read and the
//   restore, and last wait and emit. A new request is taken only once the last
//   is emitted; the output register lets the next request in while a result waits.
// Reset clears config, sequencer and state, not request latch or item results;
//   log words stay: the fill count marks them empty, so no clearing is needed.
// ----------------------------------------------------------------------------
// Over-temperature alarm with color indicator and a wear-levelled event log,
// run by a small microcoded sequencer over a plain datapath.
// ----------------------------------------------------------------------------
module overtemp_alarm_with_wear_levelled_log_top #(
  parameter int unsigned LOG_WORDS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [otalog_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [otalog_pkg::DATA_W-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_tick[15:0], temperature[31:16]
  input  logic [otalog_pkg::IN_W-1:0]       s_axis_tdata,
  // action[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sampled[0], alarm_on[1], buzzer_command[3:2], color[5:4], color_changed[6],
  // event_count[22:7], log_written[23], log_slot[29:24], log_erased[30], pad[31]
  output logic [otalog_pkg::OUT_W-1:0]      m_axis_tdata
);
  import otalog_pkg::*;

  localparam int unsigned IDX_W = (LOG_WORDS > 1) ? $clog2(LOG_WORDS) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_WORDS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LOG_WORDS);

  // configuration
  logic        [DATA_W-1:0] interval_q;
  logic signed [DATA_W-1:0] alarm_thr_q, red_thr_q, yel_thr_q, grn_thr_q;

  // request latch
  logic                     action_q;
  logic        [DATA_W-1:0] tick_q;
  logic signed [DATA_W-1:0] temp_q;

  // block state
  logic [DATA_W-1:0] last_tick_q, last_tick_d;
  logic              alarm_q, alarm_d;
  logic [2:0]        color_q, color_d;
  logic [DATA_W-1:0] events_q, events_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  // per-item results
  logic              sampled_q, sampled_d;
  logic [1:0]        buzzer_q, buzzer_d;
  logic              changed_q, changed_d;
  logic              written_q, written_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              erased_q, erased_d;

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   jump;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  // log memory
  logic [DATA_W-1:0] log_mem [LOG_WORDS];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;

  // datapath helpers
  logic              accept;
  logic              due, raise, clear_ok, log_full;
  logic [2:0]        col;
  logic signed [DATA_W:0] clr_lvl;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [1:0]        color_out;

  assign uw     = ucode_rom(pc_q);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign due      = (tick_q - last_tick_q) >= interval_q;
  assign raise    = (temp_q >= alarm_thr_q) && !alarm_q;
  assign clr_lvl  = $signed({alarm_thr_q[DATA_W-1], alarm_thr_q}) - $signed(CLEAR_MARGIN);
  assign clear_ok = $signed({temp_q[DATA_W-1], temp_q}) <= clr_lvl;
  assign log_full = (fill_q == FULL_CNT);

  always_comb begin
    if (temp_q >= red_thr_q) begin
      col = COLOR_RED;
    end else if (temp_q >= yel_thr_q) begin
      col = COLOR_YELLOW;
    end else if (temp_q >= grn_thr_q) begin
      col = COLOR_GREEN;
    end else begin
      col = COLOR_BLUE;
    end
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_REQ:   jump = !s_axis_tvalid;
      C_RESTORE:  jump = action_q;
      C_NOT_DUE:  jump = !due;
      C_NO_RAISE: jump = !raise;
      C_OUT_BUSY: jump = out_valid_q && !m_axis_tready;
      default:    jump = 1'b1;
    endcase
  end

  assign slot_ext  = {{SLOT_W{1'b0}}, slot_q};
  assign color_out = (color_q == COLOR_NONE) ? 2'd0 : color_q[1:0];

  always_comb begin
    pc_d        = jump ? uw.target : pc_q + pc_t'(1);
    last_tick_d = last_tick_q;
    alarm_d     = alarm_q;
    color_d     = color_q;
    events_d    = events_q;
    fill_d      = fill_q;
    sampled_d   = sampled_q;
    buzzer_d    = buzzer_q;
    changed_d   = changed_q;
    written_d   = written_q;
    slot_d      = slot_q;
    erased_d    = erased_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = log_full ? '0 : fill_q[IDX_W-1:0];
    mem_raddr   = IDX_W'(fill_q - CNT_W'(1));
    s_axis_tready = 1'b0;

    unique case (uw.uop)
      U_FETCH: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          sampled_d = 1'b0;
          buzzer_d  = BUZZ_NONE;
          changed_d = 1'b0;
          written_d = 1'b0;
          slot_d    = '0;
          erased_d  = 1'b0;
        end
      end
      U_NOP: begin
      end
      U_SAMPLE: begin
        sampled_d   = 1'b1;
        last_tick_d = tick_q;
        if (temp_q < alarm_thr_q && clear_ok && alarm_q) begin
          buzzer_d = BUZZ_STOP;
          alarm_d  = 1'b0;
        end
        if (color_q != col) begin
          color_d   = col;
          changed_d = 1'b1;
        end
      end
      U_RAISE: begin
        buzzer_d = BUZZ_START;
        alarm_d  = 1'b1;
        if (events_q != COUNT_MAX) begin
          events_d = events_q + DATA_W'(1);
        end
      end
      U_APPEND: begin
        mem_we    = 1'b1;
        written_d = 1'b1;
        erased_d  = log_full;
        slot_d    = mem_waddr;
        fill_d    = CNT_W'(mem_waddr) + CNT_W'(1);
      end
      U_RD_ADDR: begin
        if (fill_q != '0) begin
          mem_re = 1'b1;
          slot_d = mem_raddr;
        end
      end
      U_RESTORE: begin
        events_d = (fill_q != '0) ? rd_data_q : '0;
      end
      U_EMIT: begin
        out_valid_d = 1'b1;
        out_data_d  = {1'b0, erased_q, slot_ext[SLOT_W-1:0], written_q, events_q,
                       changed_q, color_out, buzzer_q, alarm_q, sampled_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= RST_INTERVAL;
      alarm_thr_q <= RST_ALARM_THR;
      red_thr_q   <= RST_RED_THR;
      yel_thr_q   <= RST_YEL_THR;
      grn_thr_q   <= RST_GRN_THR;
      pc_q        <= PC_FETCH;
      last_tick_q <= '0;
      alarm_q     <= 1'b0;
      color_q     <= COLOR_NONE;
      events_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_INTERVAL:  interval_q  <= cfg_wdata_i;
          REG_ALARM_THR: alarm_thr_q <= cfg_wdata_i;
          REG_RED_THR:   red_thr_q   <= cfg_wdata_i;
          REG_YEL_THR:   yel_thr_q   <= cfg_wdata_i;
          REG_GRN_THR:   grn_thr_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      pc_q        <= pc_d;
      last_tick_q <= last_tick_d;
      alarm_q     <= alarm_d;
      color_q     <= color_d;
      events_q    <= events_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= s_axis_tuser;
      tick_q   <= s_axis_tdata[DATA_W-1:0];
      temp_q   <= s_axis_tdata[2*DATA_W-1:DATA_W];
    end
    sampled_q  <= sampled_d;
    buzzer_q   <= buzzer_d;
    changed_q  <= changed_d;
    written_q  <= written_d;
    slot_q     <= slot_d;
    erased_q   <= erased_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      log_mem[mem_waddr] <= events_q;
    end
    if (mem_re) begin
      rd_data_q <= log_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[design/otalog_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otalog_chk
// Port-level checks of the over-temperature alarm block, bound to the top.
// ----------------------------------------------------------------------------
module otalog_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [otalog_pkg::OUT_W-1:0] m_axis_tdata
);
  import otalog_pkg::*;

  // sequencer is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while sequencer busy");

  // a log append only comes with a raised alarm and a start command
  a_write_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |->
      m_axis_tdata[0] && m_axis_tdata[1] && (m_axis_tdata[3:2] == BUZZ_START))
    else $error("log write without alarm raise");

  // an erase always restarts the log at word zero
  a_erase_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30] |->
      m_axis_tdata[23] && (m_axis_tdata[29:24] == 6'd0))
    else $error("log erase not followed by write at word zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind overtemp_alarm_with_wear_levelled_log_top otalog_chk u_otalog_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
